// ===== sv/tmtc_pkg.sv =====
// Shared types and constants for the timed motor task controller.
package tmtc_pkg;

  localparam int ID_BITS   = 16;
  localparam int TIME_BITS = 32;

  localparam logic signed [15:0] POWER_MIN = -16'sd1000;
  localparam logic signed [15:0] POWER_MAX = 16'sd1000;

  typedef logic [ID_BITS-1:0]   id_t;
  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_TICK = 2'd1,
    ACT_READ = 2'd2,
    ACT_STOP = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        task_id;
    logic signed [15:0] power;
    logic [31:0]        run_ms;
    logic [31:0]        now_ms;
  } tmtc_in_t;

  typedef struct packed {
    logic        accepted;
    logic        drive_forward;
    logic        drive_reverse;
    logic        busy_res;
    logic        ack_waiting;
    logic [15:0] ack_task_id;
  } tmtc_out_t;

  typedef struct packed {
    logic  running;
    logic  ack_pending;
    id_t   running_id;
    time_t start_time;
    time_t run_length;
    logic  pin_forward;
    logic  pin_reverse;
    id_t   ack_id;
  } tmtc_state_t;

endpackage

// ===== sv/tmtc_core.sv =====
// Next-state and result logic for one command of the timed motor task controller.
module tmtc_core
  import tmtc_pkg::*;
(
  input  tmtc_state_t cur,
  input  tmtc_in_t    item,
  output tmtc_state_t nxt,
  output tmtc_out_t   res
);

  id_t     id;
  time_t   dur;
  time_t   now;
  time_t   diff;
  action_t act;
  logic    bad_send;
  logic    acc;
  id_t     ack_out;
  logic    fwd;
  logic    rev;

  assign act      = action_t'(item.action);
  assign id       = id_t'(item.task_id);
  assign dur      = time_t'(item.run_ms);
  assign now      = time_t'(item.now_ms);
  assign diff     = now - cur.start_time;
  assign bad_send = (dur == '0) || (item.power < POWER_MIN) || (item.power > POWER_MAX);
  assign fwd      = item.power > 16'sd0;
  assign rev      = item.power < 16'sd0;

  always_comb begin
    nxt     = cur;
    acc     = 1'b0;
    ack_out = '0;
    unique case (act)
      ACT_SEND: begin
        if (bad_send) begin
          acc = 1'b0;
        end else if (cur.running) begin
          // A retry of the running task is acknowledged and changes nothing.
          acc = (id == cur.running_id);
        end else if (!cur.ack_pending) begin
          acc             = 1'b1;
          nxt.pin_forward = fwd;
          nxt.pin_reverse = rev;
          nxt.running_id  = id;
          nxt.start_time  = now;
          nxt.running     = fwd || rev;
          if (fwd || rev) begin
            nxt.run_length = dur;
          end else begin
            nxt.run_length  = '0;
            nxt.ack_id      = id;
            nxt.ack_pending = 1'b1;
          end
        end
      end
      ACT_TICK: begin
        // A negative difference means the clock stepped back; not yet elapsed.
        if (cur.running && !diff[TIME_BITS-1] && (diff >= cur.run_length)) begin
          nxt.pin_forward = 1'b0;
          nxt.pin_reverse = 1'b0;
          nxt.running     = 1'b0;
          nxt.run_length  = '0;
          nxt.ack_id      = cur.running_id;
          nxt.ack_pending = 1'b1;
        end
      end
      ACT_READ: begin
        if (cur.ack_pending) begin
          acc             = 1'b1;
          ack_out         = cur.ack_id;
          nxt.ack_pending = 1'b0;
        end
      end
      ACT_STOP: begin
        nxt.running     = 1'b0;
        nxt.run_length  = '0;
        nxt.pin_forward = 1'b0;
        nxt.pin_reverse = 1'b0;
      end
      default: nxt = cur;
    endcase
  end

  always_comb begin
    res.accepted      = acc;
    res.drive_forward = nxt.pin_forward;
    res.drive_reverse = nxt.pin_reverse;
    res.busy_res      = nxt.running;
    res.ack_waiting   = nxt.ack_pending;
    res.ack_task_id   = 16'(ack_out);
  end

endmodule

// ===== sv/timed_motor_task_controller.sv =====
// Top level of the timed motor task controller: input register, state and result register.
//
//   channel | direction | payload    | handshake
//   in_     | input     | tmtc_in_t  | in_valid / in_stall
//   out_    | output    | tmtc_out_t | out_valid / out_stall
//
// A command is registered on transfer and evaluated against the task state once the
// output register is free, when its result is loaded into the output register.
// One command per cycle is sustained while the output is not stalled.
// Reset clears the task state and both valid flags; payload registers are not reset.
// A stalled output register holds its result, and the input stage stalls behind it.
module timed_motor_task_controller
  import tmtc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tmtc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output tmtc_out_t out_data
);

  logic        s1_valid_r;
  tmtc_in_t    s1_data_r;
  logic        out_valid_r;
  tmtc_out_t   out_data_r;
  tmtc_state_t state_r;
  tmtc_state_t state_nxt;
  tmtc_out_t   res_nxt;
  logic        advance;

  // The registered command is evaluated when the output register is free.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  tmtc_core u_core (
    .cur  (state_r),
    .item (s1_data_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.pin_forward && state_r.pin_reverse))
    else $error("both direction pins are driven");

  a_running_drives: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.running |-> (state_r.pin_forward || state_r.pin_reverse))
    else $error("task runs with both pins off");

  a_running_no_ack: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.running |-> !state_r.ack_pending)
    else $error("task runs while an ack is pending");

  a_idle_no_length: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.running |-> (state_r.run_length == '0))
    else $error("run length kept with no task running");

  a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("evaluated command produced no result");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the timed motor task controller.
module tb
  import tmtc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 60;
  localparam int ITEMS_PER_PHASE = 240;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  tmtc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  tmtc_out_t out_data;

  tmtc_in_t    cmd_q[$];
  tmtc_out_t   result_q[$];
  tmtc_state_t motor;

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;
  int   mismatches = 0;
  int   quiet_cycles = 0;
  time_t ms_clock = '0;
  id_t   last_id = '0;

  timed_motor_task_controller u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one command to the motor state and returns the result it produces.
  function automatic tmtc_out_t motor_step(tmtc_in_t cmd);
    tmtc_out_t r;
    time_t     elapsed;
    r = '0;
    case (action_t'(cmd.action))
      ACT_SEND: begin
        if (cmd.run_ms == '0 || $signed(cmd.power) < POWER_MIN ||
            $signed(cmd.power) > POWER_MAX) begin
          r.accepted = 1'b0;
        end else if (motor.running) begin
          r.accepted = (cmd.task_id == motor.running_id);
        end else if (motor.ack_pending) begin
          r.accepted = 1'b0;
        end else begin
          r.accepted = 1'b1;
          motor.pin_forward = $signed(cmd.power) > 0;
          motor.pin_reverse = $signed(cmd.power) < 0;
          motor.running_id = cmd.task_id;
          motor.start_time = cmd.now_ms;
          motor.running = motor.pin_forward || motor.pin_reverse;
          if (motor.running) begin
            motor.run_length = cmd.run_ms;
          end else begin
            // Zero power completes at once.
            motor.run_length = '0;
            motor.ack_id = cmd.task_id;
            motor.ack_pending = 1'b1;
          end
        end
      end
      ACT_TICK: begin
        elapsed = cmd.now_ms - motor.start_time;
        // A small step back in time shows up as a negative difference.
        if (motor.running && !elapsed[TIME_BITS-1] && elapsed >= motor.run_length) begin
          motor.pin_forward = 1'b0;
          motor.pin_reverse = 1'b0;
          motor.running = 1'b0;
          motor.run_length = '0;
          motor.ack_id = motor.running_id;
          motor.ack_pending = 1'b1;
        end
      end
      ACT_READ: begin
        if (motor.ack_pending) begin
          r.accepted = 1'b1;
          r.ack_task_id = motor.ack_id;
          motor.ack_pending = 1'b0;
        end
      end
      default: begin
        motor.running = 1'b0;
        motor.run_length = '0;
        motor.pin_forward = 1'b0;
        motor.pin_reverse = 1'b0;
      end
    endcase
    r.drive_forward = motor.pin_forward;
    r.drive_reverse = motor.pin_reverse;
    r.busy_res = motor.running;
    r.ack_waiting = motor.ack_pending;
    return r;
  endfunction

  function automatic tmtc_in_t cmd_of(action_t act, logic [15:0] id, logic [15:0] pw,
                                      logic [31:0] dur, logic [31:0] now);
    tmtc_in_t c;
    c.action = act;
    c.task_id = id;
    c.power = pw;
    c.run_ms = dur;
    c.now_ms = now;
    return c;
  endfunction

  // Mostly well-formed traffic on a running clock, with some out-of-range noise.
  function automatic tmtc_in_t random_cmd();
    tmtc_in_t c;
    int       pick;
    int       r;
    c.task_id = 16'($urandom);
    c.power = 16'($urandom);
    c.run_ms = $urandom;
    c.now_ms = $urandom;
    pick = $urandom_range(99);
    if (pick < 35) begin
      c.action = ACT_SEND;
      r = $urandom_range(99);
      if (r < 30) c.task_id = last_id;
      else if (r < 90) c.task_id = 16'($urandom_range(3));
      last_id = c.task_id;
      r = $urandom_range(99);
      if (r < 10) c.power = '0;
      else if (r < 15) c.power = 16'sd1000;
      else if (r < 20) c.power = -16'sd1000;
      else if (r < 23) c.power = 16'sd1001;
      else if (r < 26) c.power = -16'sd1001;
      else if (r >= 36) c.power = 16'($urandom_range(2000) - 1000);
      r = $urandom_range(99);
      if (r < 8) c.run_ms = '0;
      else if (r >= 15) c.run_ms = $urandom_range(40, 1);
      c.now_ms = ms_clock;
    end else if (pick < 75) begin
      c.action = ACT_TICK;
      r = $urandom_range(99);
      if (r < 8) begin
        c.now_ms = ms_clock - $urandom_range(50, 1);
      end else if (r >= 12) begin
        ms_clock = ms_clock + $urandom_range(15);
        c.now_ms = ms_clock;
      end
    end else if (pick < 95) begin
      c.action = ACT_READ;
    end else begin
      c.action = ACT_STOP;
    end
    return c;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: the prediction is made when a command transfer happens.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) result_q.push_back(motor_step(in_data));
      if (!in_valid || !in_stall) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= cmd_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and result-side stall control.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          tmtc_out_t want;
          want = result_q.pop_front();
          check_field("accepted", want.accepted, out_data.accepted);
          check_field("drive_forward", want.drive_forward, out_data.drive_forward);
          check_field("drive_reverse", want.drive_reverse, out_data.drive_reverse);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("ack_waiting", want.ack_waiting, out_data.ack_waiting);
          check_field("ack_task_id", want.ack_task_id, out_data.ack_task_id);
        end
      end
      if (hold_cnt > 0) begin
        out_stall <= 1'b1;
        hold_cnt <= hold_cnt - 1;
      end else if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_cnt <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic run_random(input int idle, input int stall, input time_t clock_start);
    @(negedge clk);
    send_idle_pct = idle;
    stall_pct = stall;
    ms_clock = clock_start;
    repeat (ITEMS_PER_PHASE) cmd_q.push_back(random_cmd());
    while (cmd_q.size() != 0 || in_valid) @(negedge clk);
  endtask

  initial begin
    motor = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: rejections, retry, backwards time, wrap, zero power, stop.
    cmd_q.push_back(cmd_of(ACT_READ, 16'h1234, 16'h0005, 32'd9, 32'd0));
    cmd_q.push_back(cmd_of(ACT_TICK, 16'h0000, 16'h0000, 32'd0, 32'd500));
    cmd_q.push_back(cmd_of(ACT_SEND, 16'h0001, 16'd500, 32'd0, 32'd0));
    cmd_q.push_back(cmd_of(ACT_SEND, 16'h0001, 16'sd1001, 32'd5, 32'd0));
    cmd_q.push_back(cmd_of(ACT_SEND, 16'h0001, -16'sd1001, 32'd5, 32'd0));
    cmd_q.push_back(cmd_of(ACT_SEND, 16'h0001, 16'h8000, 32'hFFFF_FFFF, 32'd0));
    cmd_q.push_back(cmd_of(ACT_SEND, 16'hFFFF, 16'sd1000, 32'd10, 32'd100));
    cmd_q.push_back(cmd_of(ACT_SEND, 16'hFFFF, -16'sd5, 32'd3, 32'd101));
    cmd_q.push_back(cmd_of(ACT_SEND, 16'h0001, 16'sd10, 32'd3, 32'd101));
    cmd_q.push_back(cmd_of(ACT_TICK, 16'h0000, 16'h0000, 32'd0, 32'd105));
    cmd_q.push_back(cmd_of(ACT_TICK, 16'h0000, 16'h0000, 32'd0, 32'd50));
    cmd_q.push_back(cmd_of(ACT_TICK, 16'h0000, 16'h0000, 32'd0, 32'd110));
    cmd_q.push_back(cmd_of(ACT_SEND, 16'h0002, -16'sd1000, 32'd4, 32'd111));
    cmd_q.push_back(cmd_of(ACT_READ, 16'h0000, 16'h0000, 32'd0, 32'd0));
    cmd_q.push_back(cmd_of(ACT_SEND, 16'h0003, -16'sd1000, 32'hFFFF_FFFF, 32'hFFFF_FFF0));
    cmd_q.push_back(cmd_of(ACT_TICK, 16'h0000, 16'h0000, 32'd0, 32'h0000_0010));
    cmd_q.push_back(cmd_of(ACT_STOP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    cmd_q.push_back(cmd_of(ACT_SEND, 16'h0004, 16'h0000, 32'd1, 32'd0));
    cmd_q.push_back(cmd_of(ACT_READ, 16'hFFFF, 16'sd32767, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    cmd_q.push_back(cmd_of(ACT_READ, 16'h0000, 16'h0000, 32'd0, 32'd0));
    cmd_q.push_back(cmd_of(ACT_SEND, 16'h0000, 16'sd1, 32'd1, 32'h7FFF_FFFF));
    cmd_q.push_back(cmd_of(ACT_TICK, 16'h0000, 16'h0000, 32'd0, 32'h8000_0000));
    cmd_q.push_back(cmd_of(ACT_STOP, 16'h0000, 16'h0000, 32'd0, 32'd0));
    cmd_q.push_back(cmd_of(ACT_READ, 16'h0000, 16'h0000, 32'd0, 32'd0));
    cmd_q.push_back(cmd_of(ACT_SEND, 16'h0005, 16'sd32767, 32'd5, 32'd0));
    while (cmd_q.size() != 0 || in_valid) @(negedge clk);

    // The long hold-off in the first random phase backs the block up to its input.
    @(negedge clk);
    hold_req = 1'b1;
    run_random(0, 0, 32'd1000);
    run_random(59, 0, 32'hFFFF_FC00);
    run_random(0, 59, 32'h7FFF_FF00);
    run_random(15, 15, 32'd0);

    while (result_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
